FILE: rtl/core/log_domain_mul_square_sqrt_top_assert.svh
// assertion macros for the log-domain multiply, square and square root unit
`ifndef LOG_DOMAIN_MUL_SQUARE_SQRT_TOP_ASSERT_SVH
`define LOG_DOMAIN_MUL_SQUARE_SQRT_TOP_ASSERT_SVH

// check on clk, quiet while arst_n is low
`define LDMSS_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ldmss: assertion failed");

// check on clk that also holds while reset is applied
`define LDMSS_ASSERT_RST(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("ldmss: reset assertion failed");

`endif

FILE: rtl/core/ldmss_pkg.sv
// shared types, constants and the approximate log function of the log-domain unit
`default_nettype none

package ldmss_pkg;

	// operation selector carried in tuser
	typedef enum logic [1:0] {
		OP_MUL    = 2'd0,
		OP_SQUARE = 2'd1,
		OP_SQRT   = 2'd2
	} op_t;

	localparam int OPND_W = 15;  // operand width, signed
	localparam int LOG_FB = 16;  // fraction bits of a log value
	localparam int LOG_W  = 20;  // 4 integer bits plus fraction
	localparam int SUM_W  = 21;  // log sum of two operands
	localparam int OUT_FB = 30;  // fraction bits of the result
	localparam int MANT_W = 17;  // antilog mantissa 1.f
	localparam int MAG_W  = 31;  // result magnitude before sign
	localparam int RES_W  = 32;  // signed result width
	localparam int SAT_SH = 15;  // left shift at which the magnitude saturates

	// leading-one position plus linear fraction of an unsigned magnitude
	function automatic logic [LOG_W-1:0] approx_log(input logic [OPND_W-1:0] m);
		logic [3:0]          k;
		logic [OPND_W-1:0]   rem;
		logic [OPND_W+LOG_FB-1:0] sh;
		k = '0;
		for (int i = 0; i < OPND_W; i++) begin
			if (m[i]) begin
				k = 4'(i);
			end
		end
		rem = m;
		rem[k] = 1'b0;
		sh = {rem, {LOG_FB{1'b0}}} >> k;
		return {k, sh[LOG_FB-1:0]};
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/log_domain_mul_square_sqrt_top.sv
// log-domain multiply, square and square root unit, approximate in the Mitchell style
// a result is offered from the result register, which follows the input register
// throughput: one transaction per cycle while m_axis_tready is high, set by the
// single log/antilog pass between the input register and the result register
// reset: arst_n clears the stage valid flags at once; payload registers keep garbage
`default_nettype none

module log_domain_mul_square_sqrt_top #(
	parameter int FRAC_BITS = 14
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [14:0] operand_a, [29:15] operand_b, [31:30] zero
	input  wire logic [1:0]  s_axis_tuser,   // [1:0] op
	// output stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata    // [31:0] result_value
);

	localparam int OPND_W  = ldmss_pkg::OPND_W;
	localparam int LOG_W   = ldmss_pkg::LOG_W;
	localparam int SUM_W   = ldmss_pkg::SUM_W;
	localparam int LOG_FB  = ldmss_pkg::LOG_FB;
	localparam int MANT_W  = ldmss_pkg::MANT_W;
	localparam int MAG_W   = ldmss_pkg::MAG_W;
	localparam int RES_W   = ldmss_pkg::RES_W;
	localparam int EXP_BIAS = ldmss_pkg::OUT_FB - ldmss_pkg::LOG_FB;
	localparam int DIV_SQ  = 2 * FRAC_BITS;
	localparam int DIV_RT  = FRAC_BITS / 2;

	// stage registers
	logic                     valid_s1;
	ldmss_pkg::op_t           op_s1;
	logic signed [OPND_W-1:0] a_s1;
	logic signed [OPND_W-1:0] b_s1;
	logic                     valid_s2;
	logic [RES_W-1:0]         res_s2;

	logic en_s2;
	logic en_s1;

	// pipeline advance
	assign en_s2         = !valid_s2 || m_axis_tready;
	assign en_s1         = !valid_s1 || en_s2;
	assign s_axis_tready = en_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && s_axis_tvalid) begin
			op_s1 <= ldmss_pkg::op_t'(s_axis_tuser[1:0]);
			a_s1  <= s_axis_tdata[OPND_W-1:0];
			b_s1  <= s_axis_tdata[2*OPND_W-1:OPND_W];
		end
	end

	// magnitudes and logs
	logic [OPND_W-1:0] mag_a;
	logic [OPND_W-1:0] mag_b;
	logic [OPND_W-1:0] pos_a;
	logic [LOG_W-1:0]  log_a;
	logic [LOG_W-1:0]  log_b;
	logic [LOG_W-1:0]  log_pa;

	always_comb begin
		mag_a  = a_s1[OPND_W-1] ? OPND_W'(-a_s1) : OPND_W'(a_s1);
		mag_b  = b_s1[OPND_W-1] ? OPND_W'(-b_s1) : OPND_W'(b_s1);
		pos_a  = a_s1[OPND_W-1] ? '0 : OPND_W'(a_s1);
		log_a  = ldmss_pkg::approx_log(mag_a);
		log_b  = ldmss_pkg::approx_log(mag_b);
		log_pa = ldmss_pkg::approx_log(pos_a);
	end

	// combine logs, pick exponent and sign per operation
	logic [SUM_W-1:0]  lsum;
	logic signed [7:0] expo;
	logic              neg;
	logic              zero;

	always_comb begin
		lsum = '0;
		expo = '0;
		neg  = 1'b0;
		zero = 1'b0;
		unique case (op_s1)
			ldmss_pkg::OP_MUL: begin
				lsum = {1'b0, log_a} + {1'b0, log_b};
				expo = 8'(EXP_BIAS - DIV_SQ);
				neg  = a_s1[OPND_W-1] ^ b_s1[OPND_W-1];
				zero = (a_s1 == '0) || (b_s1 == '0);
			end
			ldmss_pkg::OP_SQUARE: begin
				lsum = {log_a, 1'b0};
				expo = 8'(EXP_BIAS - DIV_SQ);
			end
			ldmss_pkg::OP_SQRT: begin
				lsum = {2'b00, log_pa[LOG_W-1:1]};
				expo = 8'(EXP_BIAS - DIV_RT);
			end
			default: begin
				zero = 1'b1;
			end
		endcase
	end

	// antilog with saturation and sign
	logic [MANT_W-1:0] mant;
	logic signed [7:0] shamt;
	logic signed [7:0] rsh;
	logic [MAG_W-1:0]  mag_r;
	logic [RES_W-1:0]  res_d;

	always_comb begin
		mant  = {1'b1, lsum[LOG_FB-1:0]};
		shamt = $signed({3'b000, lsum[SUM_W-1:LOG_FB]}) + expo;
		rsh   = -shamt;
		if (zero) begin
			mag_r = '0;
		end else if (shamt >= 8'(ldmss_pkg::SAT_SH)) begin
			mag_r = '1;
		end else if (shamt >= 8'sd0) begin
			mag_r = MAG_W'({{(MAG_W-MANT_W){1'b0}}, mant} << shamt[3:0]);
		end else if (rsh >= 8'(MANT_W)) begin
			mag_r = '0;
		end else begin
			mag_r = MAG_W'(mant >> rsh[4:0]);
		end
		res_d = neg ? RES_W'(-{1'b0, mag_r}) : {1'b0, mag_r};
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			res_s2 <= res_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = res_s2;

	// checks
`include "log_domain_mul_square_sqrt_top_assert.svh"

	`LDMSS_ASSERT(a_advance_fills_output, valid_s1 && en_s2 |=> m_axis_tvalid)
	`LDMSS_ASSERT(a_mul_by_zero, valid_s1 && en_s2 && zero |=> m_axis_tdata == '0)
	`LDMSS_ASSERT(a_no_most_negative, m_axis_tvalid |-> m_axis_tdata != 32'h8000_0000)
	`LDMSS_ASSERT_RST(a_reset_empty, !arst_n |-> !m_axis_tvalid && s_axis_tready)

endmodule

`default_nettype wire
